// ===== rtl/core/ipck_pkg.sv =====
package ipck_pkg;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [7:0]  TCP_PROTO = 8'd6;
  localparam logic [3:0]  IP_VERSION = 4'd4;
  localparam logic [16:0] CKSUM_OFFSET_IP = 17'd10;
  localparam logic [16:0] CKSUM_OFFSET_TCP = 17'd16;
  localparam logic [16:0] ADDR_FIRST = 17'd12;
  localparam logic [16:0] ADDR_END = 17'd20;
  localparam int          QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_IPV4     = 3'd1,
    ST_NOT_TCP      = 3'd2,
    ST_HDR_TOO_LONG = 3'd3,
    ST_LEN_MISMATCH = 3'd4
  } status_t;

  // One word of work for the accumulator side. A zero word leaves a sum unchanged.
  typedef struct packed {
    logic [15:0] hdr_word;
    logic [15:0] seg_word;
    logic [15:0] tail_add;
    status_t     status;
    logic        last;
  } work_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

// ===== rtl/core/ipv4_tcp_checksum_recompute.sv =====
// Channel  Direction  Accept when            Payload
// in_      slave      in_tvalid & in_tready   tdata[7:0] data_byte, tlast last_byte
// out_     master     out_tvalid & out_tready tdata ip_checksum, tcp_checksum, status
//
// One byte is taken per cycle while the queue has room; a result follows the last byte
// from the front stage into the two-entry queue, then from the accumulator into the output register.
// The accumulator keeps header and segment sums with 16-bit end-around adds per queue item.
// Reset is synchronous, active low, and empties the queue and clears both sums.
// A stalled output holds the queue only once it reaches a packet's last byte.
module ipv4_tcp_checksum_recompute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // ip_checksum[15:0], tcp_checksum[31:16], status[34:32]
);

  logic            push, pop, q_ready, q_valid;
  ipck_pkg::work_t push_item, q_item;

  ipck_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready)
  );

  ipck_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  ipck_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[34:32] != 3'd0) |-> (out_tdata[31:0] == 32'd0))
    else $error("checksums not zero on an error status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34:32] <= 3'd4 && out_tdata[39:35] == 5'd0))
    else $error("status code or padding out of range");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("block not empty after reset");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// ===== rtl/core/ipck_front.sv =====
module ipck_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // data_byte[7:0]
  input  logic            in_tlast,
  output logic            push,
  output ipck_pkg::work_t push_item,
  input  logic            q_ready
);

  logic [16:0] cnt_r, cnt_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [3:0]  ver_r, ver_nxt;
  logic [15:0] tl_r, tl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [7:0]  held_r, held_nxt;

  logic [16:0] pos;
  logic [16:0] hdr_bytes;
  logic [15:0] word;
  logic [15:0] seg_len;
  logic        in_hdr, in_seg, in_addr;
  ipck_pkg::status_t status;

  assign in_tready = q_ready;
  assign push = in_tvalid && q_ready;

  always_comb begin
    ihl_nxt = ihl_r;
    ver_nxt = ver_r;
    tl_nxt = tl_r;
    proto_nxt = proto_r;
    held_nxt = held_r;
    if (cnt_r == 17'd0) begin
      ver_nxt = in_tdata[7:4];
      ihl_nxt = in_tdata[3:0];
    end else if (cnt_r == 17'd2) begin
      tl_nxt = {in_tdata, tl_r[7:0]};
    end else if (cnt_r == 17'd3) begin
      tl_nxt = {tl_r[15:8], in_tdata};
    end else if (cnt_r == 17'd9) begin
      proto_nxt = in_tdata;
    end
    if (!cnt_r[0]) held_nxt = in_tdata;
    cnt_nxt = (cnt_r < ipck_pkg::COUNT_MAX) ? cnt_r + 17'd1 : cnt_r;

    // Word offset is always the even byte offset of the pair.
    pos = {cnt_r[16:1], 1'b0};
    hdr_bytes = {11'd0, ihl_nxt, 2'b00};
    if (cnt_r[0]) word = {held_r, in_tdata};
    else if (in_tlast) word = {in_tdata, 8'h00};
    else word = 16'h0000;

    in_hdr = (pos < hdr_bytes) && (pos != ipck_pkg::CKSUM_OFFSET_IP);
    in_seg = (pos >= hdr_bytes) && (pos != hdr_bytes + ipck_pkg::CKSUM_OFFSET_TCP);
    in_addr = (pos >= ipck_pkg::ADDR_FIRST) && (pos < ipck_pkg::ADDR_END);

    push_item.hdr_word = in_hdr ? word : 16'h0000;
    // A word counted twice in the segment sum is the same as the word rotated left by one.
    if (in_seg && in_addr) push_item.seg_word = {word[14:0], word[15]};
    else if (in_seg || in_addr) push_item.seg_word = word;
    else push_item.seg_word = 16'h0000;

    if (cnt_nxt[16] || (cnt_nxt != {1'b0, tl_nxt})) status = ipck_pkg::ST_LEN_MISMATCH;
    else if (hdr_bytes > {1'b0, tl_nxt}) status = ipck_pkg::ST_HDR_TOO_LONG;
    else if (ver_nxt != ipck_pkg::IP_VERSION) status = ipck_pkg::ST_NOT_IPV4;
    else if (proto_nxt != ipck_pkg::TCP_PROTO) status = ipck_pkg::ST_NOT_TCP;
    else status = ipck_pkg::ST_OK;

    seg_len = tl_nxt - hdr_bytes[15:0];
    push_item.tail_add = ipck_pkg::ones_add({8'd0, ipck_pkg::TCP_PROTO}, seg_len);
    push_item.status = status;
    push_item.last = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ihl_r <= '0;
      ver_r <= '0;
      tl_r <= '0;
      proto_r <= '0;
      held_r <= '0;
    end else if (push) begin
      if (in_tlast) begin
        cnt_r <= '0;
        ihl_r <= '0;
        ver_r <= '0;
        tl_r <= '0;
        proto_r <= '0;
        held_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        ihl_r <= ihl_nxt;
        ver_r <= ver_nxt;
        tl_r <= tl_nxt;
        proto_r <= proto_nxt;
        held_r <= held_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/ipck_queue.sv =====
module ipck_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ipck_pkg::work_t push_item,
  output logic            q_ready,
  output logic            q_valid,
  output ipck_pkg::work_t q_item,
  input  logic            pop
);

  ipck_pkg::work_t slot_r [ipck_pkg::QUEUE_DEPTH];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  fill_r, fill_nxt;

  assign q_ready = (fill_r != 2'(ipck_pkg::QUEUE_DEPTH));
  assign q_valid = (fill_r != 2'd0);
  assign q_item = slot_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) fill_nxt = fill_r + 2'd1;
    else if (!push && pop) fill_nxt = fill_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== rtl/core/ipck_back.sv =====
module ipck_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  ipck_pkg::work_t q_item,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [39:0]     out_tdata
);

  logic [15:0] hdr_sum_r, hdr_sum_nxt;
  logic [15:0] seg_sum_r, seg_sum_nxt;
  logic [15:0] tcp_sum;
  logic        out_valid_r;
  logic [15:0] ip_ck_r, tcp_ck_r;
  ipck_pkg::status_t status_r;

  // A closing word needs the output register free; other words drain at once.
  assign pop = q_valid && (!q_item.last || !out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata = {5'd0, status_r, tcp_ck_r, ip_ck_r};

  always_comb begin
    hdr_sum_nxt = ipck_pkg::ones_add(hdr_sum_r, q_item.hdr_word);
    seg_sum_nxt = ipck_pkg::ones_add(seg_sum_r, q_item.seg_word);
    tcp_sum = ipck_pkg::ones_add(seg_sum_nxt, q_item.tail_add);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_sum_r <= '0;
      seg_sum_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && q_item.last) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (pop) begin
        if (q_item.last) begin
          hdr_sum_r <= '0;
          seg_sum_r <= '0;
        end else begin
          hdr_sum_r <= hdr_sum_nxt;
          seg_sum_r <= seg_sum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      status_r <= q_item.status;
      if (q_item.status == ipck_pkg::ST_OK) begin
        ip_ck_r <= ~hdr_sum_nxt;
        tcp_ck_r <= ~tcp_sum;
      end else begin
        ip_ck_r <= '0;
        tcp_ck_r <= '0;
      end
    end
  end

endmodule
